### src/lome_pkg.sv
// ----------------------------------------------------------------------------
// lome_pkg: shared types and constants for the order matching engine
// Sizes of the order store, the operation codes and the sequencer states.
// ----------------------------------------------------------------------------
package lome_pkg;

    localparam int ORDER_CAPACITY = 64;
    localparam int SYMBOL_COUNT   = 16;
    localparam int MAX_RESULTS    = 64;
    localparam int SLOT_W         = $clog2(ORDER_CAPACITY);
    localparam int FILL_W         = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_SUBMIT  = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_REDUCE  = 2'd2,
        OP_REPLACE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_LOOKUP_DONE,
        ST_SCAN,
        ST_SCAN_DONE,
        ST_FILL_RD,
        ST_FILL,
        ST_OUT,
        ST_FREE,
        ST_REST
    } state_t;

    typedef struct packed {
        logic [31:0] order_id;
        logic [31:0] new_id;
        logic [3:0]  symbol;
        logic        side;
        logic        order_type;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [63:0] timestamp;
        logic [1:0]  operation;
    } in_item_t;

    typedef struct packed {
        logic [31:0] aggressor_id;
        logic [31:0] resting_id;
        logic [31:0] fill_price;
        logic [31:0] fill_quantity;
        logic [63:0] fill_time;
        logic        last;
    } out_item_t;

endpackage

### src/lome_if.sv
// ----------------------------------------------------------------------------
// lome_if: valid/ready channel
// Carries one item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lome_in_if;
    import lome_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface lome_out_if;
    import lome_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

### src/limit_order_matching_engine_top.sv
// ----------------------------------------------------------------------------
// limit_order_matching_engine_top: price-time priority matching engine
// One shared compare unit walks the order store under a small sequencer.
// ----------------------------------------------------------------------------
// Each item walks the slot store one slot per cycle, and the block takes no
// new item until the item in hand is done and its last fill has been taken.
// Cancel, reduce and replace first walk all slots to find the id. A submit
// runs one search (walk plus decision) for the best opposite order (best
// price, then oldest arrival), and each fill adds a read and an update step;
// a new search follows every fill unless the quantity is used up or
// MAX_RESULTS fills are out. A fill that a new search follows is held in the
// output register until that search shows whether it is the last one; the
// final fill leaves from ST_OUT. A resting remainder then walks to the
// lowest free slot, passing each occupied slot, and is written in ST_REST.
// The single compare unit fed by one store read port sets the pace of each
// item, and a stalled fill side adds its stall.
// Valid bits reset at once; the other slot fields live in memory arrays.
module limit_order_matching_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    lome_in_if.sink     in_ch,
    lome_out_if.source  out_ch
);
    import lome_pkg::*;

    // slot store: one registered read port, one write port
    logic [31:0] mem_id    [ORDER_CAPACITY];
    logic [3:0]  mem_sym   [ORDER_CAPACITY];
    logic        mem_side  [ORDER_CAPACITY];
    logic [31:0] mem_price [ORDER_CAPACITY];
    logic [31:0] mem_qty   [ORDER_CAPACITY];
    logic [31:0] mem_arr   [ORDER_CAPACITY];
    logic [ORDER_CAPACITY-1:0] valid_reg, valid_next;

    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic        rd_ok_reg;
    logic [31:0] rd_id_reg, rd_price_reg, rd_qty_reg, rd_arr_reg;
    logic [3:0]  rd_sym_reg;
    logic        rd_side_reg;

    logic        wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic        wr_full;
    logic [31:0] wr_qty;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [SLOT_W:0] cnt_reg, cnt_next;
    logic        hit_reg, hit_next;
    logic [SLOT_W-1:0] best_reg, best_next;
    logic [31:0] best_price_reg, best_price_next;
    logic [31:0] best_age_reg, best_age_next;
    logic [31:0] arrival_reg, arrival_next;
    logic [FILL_W-1:0] nfill_reg, nfill_next;
    logic        ovalid_reg, ovalid_next;
    out_item_t   odata_reg, odata_next;

    logic [31:0] age, fq;
    logic better, crosses, rest_after;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (wr_full)
            begin
                mem_id[wr_addr]    <= item_reg.order_id;
                mem_sym[wr_addr]   <= item_reg.symbol;
                mem_side[wr_addr]  <= item_reg.side;
                mem_price[wr_addr] <= item_reg.price;
                mem_arr[wr_addr]   <= arrival_reg;
            end
            mem_qty[wr_addr] <= wr_qty;
        end
        rd_id_reg    <= mem_id[rd_addr];
        rd_sym_reg   <= mem_sym[rd_addr];
        rd_side_reg  <= mem_side[rd_addr];
        rd_price_reg <= mem_price[rd_addr];
        rd_qty_reg   <= mem_qty[rd_addr];
        rd_arr_reg   <= mem_arr[rd_addr];
        rd_idx_reg   <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            arrival_reg <= '0;
            nfill_reg   <= '0;
            ovalid_reg  <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            hit_reg     <= hit_next;
            arrival_reg <= arrival_next;
            nfill_reg   <= nfill_next;
            ovalid_reg  <= ovalid_next;
            rd_ok_reg   <= (cnt_reg < (SLOT_W+1)'(ORDER_CAPACITY));
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        best_reg       <= best_next;
        best_price_reg <= best_price_next;
        best_age_reg   <= best_age_next;
        odata_reg      <= odata_next;
    end

    // shared compare unit: judges the slot read last cycle
    always_comb
    begin
        age = arrival_reg - rd_arr_reg;
        if (!hit_reg)
            better = 1'b1;
        else if (rd_price_reg == best_price_reg)
            better = age > best_age_reg;
        else if (!item_reg.side)
            better = rd_price_reg < best_price_reg;
        else
            better = rd_price_reg > best_price_reg;
        crosses = item_reg.order_type ||
                  (!item_reg.side && !(best_price_reg > item_reg.price)) ||
                  (item_reg.side && !(best_price_reg < item_reg.price));
        fq = (item_reg.quantity < rd_qty_reg) ? item_reg.quantity : rd_qty_reg;
        rest_after = (item_reg.quantity != 32'd0) && !item_reg.order_type;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        best_price_next = best_price_reg;
        best_age_next   = best_age_reg;
        arrival_next    = arrival_reg;
        nfill_next      = nfill_reg;
        ovalid_next     = ovalid_reg;
        odata_next      = odata_reg;
        item_next       = item_reg;
        rd_addr         = cnt_reg[SLOT_W-1:0];
        wr_en           = 1'b0;
        wr_full         = 1'b0;
        wr_addr         = best_reg;
        wr_qty          = '0;
        in_ch.ready     = 1'b0;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !ovalid_reg;
                if (in_ch.valid && !ovalid_reg)
                begin
                    item_next  = in_ch.data;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    nfill_next = '0;
                    if (in_ch.data.operation == OP_SUBMIT)
                    begin
                        if (in_ch.data.quantity != 32'd0 &&
                            32'(in_ch.data.symbol) < 32'(SYMBOL_COUNT))
                            state_next = ST_SCAN;
                    end
                    else
                        state_next = ST_LOOKUP;
                end
            end
            // walk slots for the id; keep the lowest match
            ST_LOOKUP:
            begin
                if (cnt_reg != '0 && rd_ok_reg && !hit_reg &&
                    valid_reg[rd_idx_reg] && rd_id_reg == item_reg.order_id)
                begin
                    hit_next        = 1'b1;
                    best_next       = rd_idx_reg;
                    best_price_next = rd_qty_reg;
                    item_next.symbol = rd_sym_reg;
                    item_next.side   = rd_side_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (SLOT_W+1)'(ORDER_CAPACITY))
                    state_next = ST_LOOKUP_DONE;
            end
            ST_LOOKUP_DONE:
            begin
                state_next = ST_IDLE;
                if (hit_reg)
                begin
                    unique case (item_reg.operation)
                        OP_REDUCE:
                        begin
                            if (item_reg.quantity >= best_price_reg)
                                valid_next[best_reg] = 1'b0;
                            else
                            begin
                                wr_en  = 1'b1;
                                wr_qty = best_price_reg - item_reg.quantity;
                            end
                        end
                        OP_REPLACE:
                        begin
                            valid_next[best_reg] = 1'b0;
                            item_next.order_id   = item_reg.new_id;
                            item_next.order_type = 1'b0;
                            if (item_reg.quantity != 32'd0)
                            begin
                                cnt_next   = '0;
                                hit_next   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: valid_next[best_reg] = 1'b0;
                    endcase
                end
            end
            // best opposite order search, one slot per cycle
            ST_SCAN:
            begin
                if (cnt_reg != '0 && valid_reg[rd_idx_reg] &&
                    rd_sym_reg == item_reg.symbol && rd_side_reg != item_reg.side &&
                    better)
                begin
                    hit_next        = 1'b1;
                    best_next       = rd_idx_reg;
                    best_price_next = rd_price_reg;
                    best_age_next   = age;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (SLOT_W+1)'(ORDER_CAPACITY))
                    state_next = ST_SCAN_DONE;
            end
            ST_SCAN_DONE:
            begin
                rd_addr = best_reg;
                if (hit_reg && crosses)
                begin
                    state_next = ST_FILL_RD;
                    // another fill follows: release the held one as not last
                    if (nfill_reg != '0)
                        ovalid_next = 1'b1;
                end
                else
                    state_next = rest_after ? ST_FREE : ST_IDLE;
                cnt_next = '0;
                if (!(hit_reg && crosses) && nfill_reg != '0)
                begin
                    // mark the held fill as last
                    odata_next.last = 1'b1;
                    state_next = rest_after ? ST_FREE : ST_OUT;
                end
            end
            ST_FILL_RD:
            begin
                rd_addr = best_reg;
                state_next = ST_FILL;
            end
            // wait for the released fill to go, then hold the new one
            ST_FILL:
            begin
                rd_addr = best_reg;
                if (!ovalid_reg || out_ch.ready)
                begin
                    odata_next.aggressor_id  = item_reg.order_id;
                    odata_next.resting_id    = rd_id_reg;
                    odata_next.fill_price    = rd_price_reg;
                    odata_next.fill_quantity = fq;
                    odata_next.fill_time     = item_reg.timestamp;
                    odata_next.last          = 1'b0;
                    item_next.quantity = item_reg.quantity - fq;
                    wr_en  = 1'b1;
                    wr_qty = rd_qty_reg - fq;
                    if (rd_qty_reg == fq)
                        valid_next[best_reg] = 1'b0;
                    nfill_next = nfill_reg + 1'b1;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    if (item_reg.quantity == fq ||
                        nfill_reg == FILL_W'(MAX_RESULTS - 1))
                    begin
                        odata_next.last = 1'b1;
                        state_next = ((item_reg.quantity != fq) && !item_reg.order_type)
                                     ? ST_FREE : ST_OUT;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            // final fill waits in the output register
            ST_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            // lowest free slot for the remainder
            ST_FREE:
            begin
                if (valid_reg == {ORDER_CAPACITY{1'b1}})
                    state_next = (nfill_reg != '0) ? ST_OUT : ST_IDLE;
                else if (!valid_reg[cnt_reg[SLOT_W-1:0]])
                begin
                    best_next  = cnt_reg[SLOT_W-1:0];
                    state_next = ST_REST;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_REST:
            begin
                wr_en   = 1'b1;
                wr_full = 1'b1;
                wr_qty  = item_reg.quantity;
                valid_next[best_reg] = 1'b1;
                arrival_next = arrival_reg + 32'd1;
                state_next = (nfill_reg != '0) ? ST_OUT : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    // no item taken while a result is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> !out_ch.valid)
        else $error("item taken with result pending");
    // a fill never carries zero quantity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.data.fill_quantity != 32'd0))
        else $error("zero fill");
    // arrival stamp advances only when an order rests
    assert property (@(posedge clk) disable iff (!rst_n)
        (arrival_reg != $past(arrival_reg)) |-> ($past(state_reg) == ST_REST))
        else $error("arrival moved outside rest");

endmodule
